@@ rtl/het_pkg.sv @@
// ----------------------------------------------------------------------------
// het_pkg: shared types and constants for the hysteresis edge threshold block
// Pixel classes, register indexes and the packed item structs.
// ----------------------------------------------------------------------------
package het_pkg;

  localparam int unsigned DefMaxWidth   = 256;
  localparam int unsigned DefMaxHeight  = 256;
  localparam int unsigned DefStackDepth = 65536;

  localparam logic [16:0] CountMax = 17'h1FFFF;

  // Pixel classes as held in the class memory.
  typedef enum logic [1:0] {
    ClsNone   = 2'd0,
    ClsWeak   = 2'd1,
    ClsStrong = 2'd2,
    ClsEdge   = 2'd3
  } cls_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegLow    = 3'd0,
    RegHigh   = 3'd1,
    RegNoEdge = 3'd2,
    RegEdge   = 3'd3,
    RegWidth  = 3'd4,
    RegHeight = 3'd5,
    RegLimit  = 3'd6
  } reg_e;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] magnitude;
    logic       last;
  } het_in_t;

  typedef struct packed {
    logic [7:0]  label;
    logic [16:0] survivors;
    logic        done_res;
    logic        overflow;
  } het_out_t;

endpackage

@@ rtl/het_ram.sv @@
// ----------------------------------------------------------------------------
// het_ram: generic single-port RAM with registered read
// One access per cycle: write, or registered read.
// ----------------------------------------------------------------------------
module het_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write or registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/hysteresis_edge_threshold.sv @@
// ----------------------------------------------------------------------------
// hysteresis_edge_threshold: 8-connected hysteresis threshold with stack fill
// Loads a magnitude image, grows edges from strong pixels through weak ones,
// then returns edge labels in raster order.
// ----------------------------------------------------------------------------
// Channel   Signals                          Direction  Handshake
// item in   start_i, busy_o, in_i            in         start_i & !busy_o
// result    res_valid_o, res_o               out        one-cycle strobe
// config    psel/penable/pwrite/paddr/pwdata APB        pready always high
//
// Loads and reads take one item at a time: each goes through the
// single port of the class memory, a read then a write or result.
// The last load runs the fill: a sweep clearing unloaded pixels (one per cycle),
// then a scan that reads each pixel in turn; each pop reads its entry, then
// reads each neighbor inside the image and skips each neighbor outside it.
// busy_o is high while an item or the fill is in progress. There is no
// clearing pass after reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module hysteresis_edge_threshold #(
  parameter int unsigned MaxWidth   = het_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight  = het_pkg::DefMaxHeight,
  parameter int unsigned StackDepth = het_pkg::DefStackDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  het_pkg::het_in_t    in_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output het_pkg::het_out_t   res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import het_pkg::*;

  localparam int unsigned Pix  = MaxWidth * MaxHeight;
  localparam int unsigned AW   = $clog2(Pix);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned XW   = $clog2(MaxWidth + 1);
  localparam int unsigned YW   = $clog2(MaxHeight + 1);
  localparam int unsigned XAW  = $clog2(MaxWidth);
  localparam int unsigned YAW  = $clog2(MaxHeight);
  localparam int unsigned StkW = XAW + YAW;
  localparam int unsigned SAW  = $clog2(StackDepth);
  localparam int unsigned SW   = SAW + 1;

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StItem  = 10'b0000000010,
    StClear = 10'b0000000100,
    StScan  = 10'b0000001000,
    StScanW = 10'b0000010000,
    StPop   = 10'b0000100000,
    StPopW  = 10'b0001000000,
    StNbRd  = 10'b0010000000,
    StNbW   = 10'b0100000000,
    StDone  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [7:0]  low_q, high_q, noedge_q, edgel_q;
  logic [8:0]  width_q, height_q;
  logic [16:0] limit_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= 8'd64; high_q <= 8'd128; noedge_q <= 8'd0; edgel_q <= 8'd255;
      width_q <= 9'd256; height_q <= 9'd256; limit_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegLow:    low_q    <= pwdata[7:0];
        RegHigh:   high_q   <= pwdata[7:0];
        RegNoEdge: noedge_q <= pwdata[7:0];
        RegEdge:   edgel_q  <= pwdata[7:0];
        RegWidth:  width_q  <= pwdata[8:0];
        RegHeight: height_q <= pwdata[8:0];
        RegLimit:  limit_q  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegLow:    prdata = {24'd0, low_q};
      RegHigh:   prdata = {24'd0, high_q};
      RegNoEdge: prdata = {24'd0, noedge_q};
      RegEdge:   prdata = {24'd0, edgel_q};
      RegWidth:  prdata = {23'd0, width_q};
      RegHeight: prdata = {23'd0, height_q};
      RegLimit:  prdata = {15'd0, limit_q};
      default:   prdata = '0;
    endcase
  end

  // Effective image size and stack limit.
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [CW-1:0] count;
  logic [SW-1:0] limit_eff;
  logic [CW:0]   lim_raw;

  always_comb begin
    if (width_q == 9'd0) w_eff = XW'(1);
    else if (32'(width_q) > MaxWidth) w_eff = XW'(MaxWidth);
    else w_eff = XW'(width_q);
    if (height_q == 9'd0) h_eff = YW'(1);
    else if (32'(height_q) > MaxHeight) h_eff = YW'(MaxHeight);
    else h_eff = YW'(height_q);
    lim_raw = (limit_q == 17'd0) ? (CW+1)'(count) : (CW+1)'(limit_q);
    if (32'(lim_raw) > StackDepth) limit_eff = SW'(StackDepth);
    else limit_eff = SW'(lim_raw);
  end

  always_ff @(posedge clk_i) begin
    count <= CW'(w_eff * h_eff);
  end

  // Datapath state.
  logic [CW-1:0] load_q, load_d, read_q, read_d, scan_q, scan_d;
  logic [16:0]   edges_q, edges_d;
  logic          ovf_q, ovf_d, fdone_q, fdone_d;
  het_in_t       item_q;
  logic [SW-1:0] sp_q, sp_d;
  logic [XW-1:0] px_q, px_d, scx_q, scx_d;
  logic [YW-1:0] py_q, py_d, scy_q, scy_d;
  logic [2:0]    k_q, k_d;
  logic [AW-1:0] nidx_q, nidx_d;
  logic          res_v_d;
  het_out_t      res_d, res_q;
  logic          res_v_q;

  // Memories; stack entries hold a pixel position as row and column fields.
  logic            cm_we, sm_we;
  logic [AW-1:0]   cm_addr;
  logic [1:0]      cm_wdata, cm_rdata;
  logic [SAW-1:0]  sm_addr;
  logic [StkW-1:0] sm_wdata, sm_rdata;

  het_ram #(.Width(2), .Depth(Pix)) u_cls (
    .clk_i, .we_i(cm_we), .addr_i(cm_addr), .wdata_i(cm_wdata), .rdata_o(cm_rdata)
  );
  het_ram #(.Width(StkW), .Depth(StackDepth)) u_stk (
    .clk_i, .we_i(sm_we), .addr_i(sm_addr), .wdata_i(sm_wdata), .rdata_o(sm_rdata)
  );

  // Neighbor coordinates for the current direction.
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic                 n_in;
  logic [AW-1:0]        n_lin;
  logic [1:0]           dxs, dys;

  always_comb begin
    case (k_q)
      3'd0: begin dxs = 2'd0; dys = 2'd0; end
      3'd1: begin dxs = 2'd1; dys = 2'd0; end
      3'd2: begin dxs = 2'd2; dys = 2'd0; end
      3'd3: begin dxs = 2'd2; dys = 2'd1; end
      3'd4: begin dxs = 2'd2; dys = 2'd2; end
      3'd5: begin dxs = 2'd1; dys = 2'd2; end
      3'd6: begin dxs = 2'd0; dys = 2'd2; end
      default: begin dxs = 2'd0; dys = 2'd1; end
    endcase
    nx = $signed({2'b00, px_q}) + $signed({{XW{1'b0}}, dxs}) - (XW+2)'(1);
    ny = $signed({2'b00, py_q}) + $signed({{YW{1'b0}}, dys}) - (YW+2)'(1);
    n_in = (nx >= 0) && (ny >= 0) && (nx < $signed({2'b00, w_eff}))
        && (ny < $signed({2'b00, h_eff}));
    n_lin = AW'(ny[YW-1:0] * w_eff + nx[XW-1:0]);
  end

  logic          accept;
  logic [CW-1:0] read_w;
  logic [16:0]   edges_inc;

  assign accept    = start_i && (state_q == StIdle);
  assign busy_o    = (state_q != StIdle);
  assign read_w    = (read_q >= count) ? '0 : read_q;
  assign edges_inc = (edges_q < CountMax) ? edges_q + 17'd1 : edges_q;

  // Main sequencer.
  always_comb begin
    state_d = state_q;
    load_d = load_q; read_d = read_q; scan_d = scan_q;
    edges_d = edges_q; ovf_d = ovf_q; fdone_d = fdone_q;
    sp_d = sp_q; px_d = px_q; py_d = py_q; k_d = k_q; nidx_d = nidx_q;
    scx_d = scx_q; scy_d = scy_q;
    cm_we = 1'b0; cm_addr = '0; cm_wdata = ClsNone;
    sm_we = 1'b0; sm_addr = '0; sm_wdata = '0;
    res_v_d = 1'b0;
    res_d = '0;
    res_d.survivors = edges_q;
    res_d.overflow  = ovf_q;
    case (state_q)
      StIdle: begin
        cm_addr = AW'(read_w);
        if (accept) state_d = StItem;
      end
      StItem: begin
        if (item_q.op == OpRead) begin
          res_v_d = 1'b1;
          res_d.label = (cm_rdata == ClsEdge) ? edgel_q : noedge_q;
          res_d.done_res = fdone_q;
          read_d = ((read_w + 1'b1) >= count) ? '0 : read_w + 1'b1;
          state_d = StIdle;
        end else begin
          if (load_q < count) begin
            cm_we = 1'b1;
            cm_addr = AW'(load_q);
            if (item_q.magnitude >= high_q) cm_wdata = ClsStrong;
            else if (item_q.magnitude >= low_q) cm_wdata = ClsWeak;
            else cm_wdata = ClsNone;
            load_d = load_q + 1'b1;
          end
          if (item_q.last) begin
            state_d = StClear;
            edges_d = '0;
            ovf_d = 1'b0;
          end else begin
            fdone_d = 1'b0;
            res_v_d = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StClear: begin
        if (load_q < count) begin
          cm_we = 1'b1;
          cm_addr = AW'(load_q);
          load_d = load_q + 1'b1;
        end else begin
          scan_d = '0;
          scx_d = '0;
          scy_d = '0;
          sp_d = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_q >= count) begin
          state_d = StDone;
        end else begin
          cm_addr = AW'(scan_q);
          state_d = StScanW;
        end
      end
      StScanW: begin
        if (cm_rdata == ClsStrong) begin
          cm_we = 1'b1; cm_addr = AW'(scan_q); cm_wdata = ClsEdge;
          edges_d = edges_inc;
          sm_we = 1'b1; sm_addr = '0; sm_wdata = {scy_q[YAW-1:0], scx_q[XAW-1:0]};
          sp_d = SW'(1);
          state_d = StPop;
        end else begin
          state_d = StScan;
        end
        scan_d = scan_q + 1'b1;
        // The scan position also steps through columns and rows.
        if (scx_q == w_eff - 1'b1) begin
          scx_d = '0;
          scy_d = scy_q + 1'b1;
        end else begin
          scx_d = scx_q + 1'b1;
        end
      end
      StPop: begin
        if (sp_q == '0) begin
          state_d = StScan;
        end else begin
          sm_addr = SAW'(sp_q - 1'b1);
          sp_d = sp_q - 1'b1;
          state_d = StPopW;
        end
      end
      StPopW: begin
        // The popped entry already holds the column and row.
        px_d = XW'(sm_rdata[XAW-1:0]);
        py_d = YW'(sm_rdata[StkW-1:XAW]);
        k_d = 3'd0;
        state_d = StNbRd;
      end
      StNbRd: begin
        if (n_in) begin
          cm_addr = n_lin;
          nidx_d = n_lin;
          state_d = StNbW;
        end else if (k_q == 3'd7) begin
          state_d = StPop;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StNbW: begin
        if (cm_rdata == ClsWeak) begin
          if (sp_q < limit_eff) begin
            cm_we = 1'b1; cm_addr = nidx_q; cm_wdata = ClsEdge;
            edges_d = edges_inc;
            sm_we = 1'b1; sm_addr = SAW'(sp_q);
            sm_wdata = {ny[YAW-1:0], nx[XAW-1:0]};
            sp_d = sp_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (k_q == 3'd7) state_d = StPop;
        else begin
          k_d = k_q + 1'b1;
          state_d = StNbRd;
        end
      end
      StDone: begin
        res_v_d = 1'b1;
        res_d.done_res = 1'b1;
        load_d = '0; read_d = '0; fdone_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      load_q <= '0; read_q <= '0; scan_q <= '0;
      edges_q <= '0; ovf_q <= 1'b0; fdone_q <= 1'b0; sp_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q <= load_d; read_q <= read_d; scan_q <= scan_d;
      edges_q <= edges_d; ovf_q <= ovf_d; fdone_q <= fdone_d; sp_q <= sp_d;
      res_v_q <= res_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_i;
    px_q <= px_d; py_q <= py_d; k_q <= k_d; nidx_q <= nidx_d;
    scx_q <= scx_d; scy_q <= scy_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // The stack never grows beyond its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= limit_eff || state_q == StIdle)
    else $error("stack pointer beyond limit");
  // A result follows only from item work or the end of a fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == StItem || $past(state_q) == StDone))
    else $error("result without item");
  // An accepted item always leaves idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("accepted item not taken");

endmodule
